// ===== hdl/svbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Stream VByte decoder package
// Shared constants and the result bundle between the assembler and the top.
// ----------------------------------------------------------------------------
package svbd_pkg;

	localparam int unsigned DEFAULT_MAX_COUNT = 4096;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned COUNT_W   = 13;
	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned PARTIAL_W = 24;
	localparam int unsigned TOTAL_W   = 15;
	localparam int unsigned CODE_W    = 2;
	localparam int unsigned CODES_PER_KEY = 4;
	localparam logic [CODE_W-1:0] CODE_MASK = 2'h3;
	localparam logic [CODE_W-1:0] LAST_SLOT = 2'(CODES_PER_KEY - 1);

	// Output tdata: value, bytes_used, padded to whole bytes.
	localparam int unsigned OUT_DATA_W = ((VALUE_W + TOTAL_W + 7) / 8) * 8;

	typedef struct packed {
		logic                 valid;
		logic [VALUE_W-1:0]   value;
		logic                 is_last;
		logic [TOTAL_W-1:0]   bytes_used;
	} svbd_result_t;

endpackage

// ===== hdl/svbd_key_mem.sv =====
// ----------------------------------------------------------------------------
// Stream VByte key memory
// One write port and one registered read port; a write to the address being
// read in the same cycle is forwarded to the read data.
// ----------------------------------------------------------------------------
module svbd_key_mem #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned AW    = 10
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic [svbd_pkg::BYTE_W-1:0] wdata,
	input  logic [AW-1:0]           raddr,
	output logic [svbd_pkg::BYTE_W-1:0] rdata
);
	import svbd_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/svbd_assemble.sv =====
// ----------------------------------------------------------------------------
// Stream VByte block sequencer and value assembler
// Tracks the key and data phases, stores key bytes, prefetches the next key
// byte and builds each value from its little-endian data bytes.
// ----------------------------------------------------------------------------
module svbd_assemble #(
	parameter int unsigned MAX_COUNT = svbd_pkg::DEFAULT_MAX_COUNT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [svbd_pkg::COUNT_W-1:0]  cfg_wdata,
	input  logic                          in_fire,
	input  logic [svbd_pkg::BYTE_W-1:0]   in_byte,
	output svbd_pkg::svbd_result_t        result
);
	import svbd_pkg::*;

	localparam int unsigned KEY_DEPTH = (MAX_COUNT + 3) / 4;
	localparam int unsigned KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int unsigned KLW = $clog2(KEY_DEPTH + 1);
	localparam int unsigned CW  = $clog2(MAX_COUNT + 1);
	// Wide enough for both the written count and the limit it saturates to.
	localparam int unsigned EW  = COUNT_W + CW;

	logic [CW-1:0]        count_q;
	logic [KLW-1:0]       key_len_q;
	logic                 data_phase_q, data_phase_d;
	logic [KLW-1:0]       keys_seen_q, keys_seen_d;
	logic [CW-1:0]        done_q, done_d;
	logic [1:0]           byte_idx_q, byte_idx_d;
	logic [PARTIAL_W-1:0] partial_q, partial_d;
	logic [TOTAL_W-1:0]   total_q, total_d;
	logic [BYTE_W-1:0]    cur_key_q, cur_key_d;

	logic                 mem_we;
	logic [KAW-1:0]       mem_waddr;
	logic [KAW-1:0]       mem_raddr;
	logic [BYTE_W-1:0]    next_key;
	logic [CODE_W-1:0]    code;
	logic [TOTAL_W-1:0]   total_inc;
	logic [EW-1:0]        cfg_count_ext;
	logic [CW-1:0]        cfg_count_sat;

	svbd_key_mem #(
		.DEPTH(KEY_DEPTH),
		.AW   (KAW)
	) u_key_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(in_byte),
		.raddr(mem_raddr),
		.rdata(next_key)
	);

	assign cfg_count_ext = EW'(cfg_wdata);
	assign cfg_count_sat = (cfg_count_ext > EW'(MAX_COUNT)) ? CW'(MAX_COUNT)
		: CW'(cfg_count_ext);

	assign code      = CODE_W'(cur_key_q >> {done_q[1:0], 1'b0}) & CODE_MASK;
	assign total_inc = total_q + TOTAL_W'(1);
	assign mem_waddr = KAW'(keys_seen_q);

	always_comb begin
		data_phase_d = data_phase_q;
		keys_seen_d  = keys_seen_q;
		done_d       = done_q;
		byte_idx_d   = byte_idx_q;
		partial_d    = partial_q;
		total_d      = total_q;
		cur_key_d    = cur_key_q;
		mem_we       = 1'b0;
		result       = '0;

		if (cfg_we) begin
			data_phase_d = 1'b0;
			keys_seen_d  = '0;
			done_d       = '0;
			byte_idx_d   = '0;
			partial_d    = '0;
			total_d      = '0;
		end else if (in_fire && (count_q != '0)) begin
			total_d = total_inc;
			if (!data_phase_q) begin
				mem_we      = 1'b1;
				keys_seen_d = keys_seen_q + KLW'(1);
				if (keys_seen_d == key_len_q) begin
					data_phase_d = 1'b1;
				end
				// The first key byte goes straight to the working key register.
				if (keys_seen_q == '0) begin
					cur_key_d = in_byte;
				end
			end else if (byte_idx_q < code) begin
				partial_d  = partial_q
					| PARTIAL_W'(PARTIAL_W'(in_byte) << {byte_idx_q, 3'b000});
				byte_idx_d = byte_idx_q + 2'd1;
			end else begin
				result.valid = 1'b1;
				result.value = VALUE_W'(partial_q)
					| VALUE_W'(VALUE_W'(in_byte) << {byte_idx_q, 3'b000});
				if ((done_q + CW'(1)) == count_q) begin
					result.is_last    = 1'b1;
					result.bytes_used = total_inc;
					data_phase_d = 1'b0;
					keys_seen_d  = '0;
					done_d       = '0;
					total_d      = '0;
				end else begin
					done_d = done_q + CW'(1);
					if (done_q[1:0] == LAST_SLOT) begin
						cur_key_d = next_key;
					end
				end
				byte_idx_d = '0;
				partial_d  = '0;
			end
		end
	end

	// The read port always fetches the key byte after the one in use, so a
	// key change never waits on the memory.
	assign mem_raddr = KAW'((done_d >> 2) + CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			key_len_q    <= '0;
			data_phase_q <= 1'b0;
			keys_seen_q  <= '0;
			done_q       <= '0;
			byte_idx_q   <= '0;
			partial_q    <= '0;
			total_q      <= '0;
		end else begin
			if (cfg_we) begin
				count_q   <= cfg_count_sat;
				key_len_q <= KLW'(((CW + 2)'(cfg_count_sat) + (CW + 2)'(3)) >> 2);
			end
			data_phase_q <= data_phase_d;
			keys_seen_q  <= keys_seen_d;
			done_q       <= done_d;
			byte_idx_q   <= byte_idx_d;
			partial_q    <= partial_d;
			total_q      <= total_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_key_q <= cur_key_d;
	end

endmodule

// ===== hdl/stream_vbyte_decoder.sv =====
// ----------------------------------------------------------------------------
// Stream VByte block decoder
// Decodes one block of value_count 32-bit integers from a byte stream.
// ----------------------------------------------------------------------------
// The decoder takes one byte per clock cycle while its input is not stalled,
// key bytes and data bytes alike. Key bytes are written to a single-port-write
// key memory with a registered read; the key byte for the next group of four
// values is always prefetched, so a value may complete on every cycle. Each
// value appears on the output in the cycle after the item carrying its last
// byte is accepted, held in an output register while the next byte is taken
// in. The input stalls only while that register is full and not being drained.
// A write of value_count restarts the block; a count of zero drops all bytes.
// ----------------------------------------------------------------------------
module stream_vbyte_decoder #(
	parameter int unsigned MAX_COUNT = svbd_pkg::DEFAULT_MAX_COUNT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [svbd_pkg::COUNT_W-1:0]     cfg_wdata,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [svbd_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] in_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [svbd_pkg::OUT_DATA_W-1:0]  m_tdata,   // [31:0] value, [46:32] bytes_used
	output logic                             m_tlast    // is_last
);
	import svbd_pkg::*;

	svbd_result_t         result;
	logic                 in_fire;
	logic                 m_tvalid_q;
	logic [VALUE_W-1:0]   value_q;
	logic [TOTAL_W-1:0]   bytes_used_q;
	logic                 last_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign in_fire  = s_tvalid && s_tready;

	svbd_assemble #(
		.MAX_COUNT(MAX_COUNT)
	) u_assemble (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_fire  (in_fire),
		.in_byte  (s_tdata),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (result.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result.valid) begin
			value_q      <= result.value;
			bytes_used_q <= result.bytes_used;
			last_q       <= result.is_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DATA_W'({bytes_used_q, value_q});
	assign m_tlast  = last_q;

endmodule

// ===== hdl/svbd_checker.sv =====
// ----------------------------------------------------------------------------
// Stream VByte decoder port checker
// Watches the top-level ports and flags behavior the decoder must never show.
// ----------------------------------------------------------------------------
module svbd_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_we,
	input logic [svbd_pkg::COUNT_W-1:0]     cfg_wdata,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [svbd_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic                             m_tlast
);
	import svbd_pkg::*;

	// A result waiting on the output holds its item.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// A full output register that is not drained blocks the input.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted while the output register is blocked");

	// The byte total is only reported with the final value of a block.
	a_total_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[VALUE_W +: TOTAL_W] == '0)
		else $error("bytes_used nonzero on a value that is not the last");

	// With a zero count, no new item can appear on the output.
	a_zero_count: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_wdata == '0) && !m_tvalid |=> !m_tvalid)
		else $error("item produced right after a zero count was written");

endmodule

bind stream_vbyte_decoder svbd_checker u_svbd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.cfg_we   (cfg_we),
	.cfg_wdata(cfg_wdata),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== tb/stream_vbyte_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream VByte decoder testbench
// Feeds encoded blocks one byte per item, decodes them alongside the block
// and checks every value, last flag and byte total that comes out.
// ----------------------------------------------------------------------------
module stream_vbyte_decoder_tb;

	import svbd_pkg::*;

	localparam int unsigned KEY_DEPTH = (DEFAULT_MAX_COUNT + 3) / 4;
	localparam int unsigned RANDOM_ITEMS = 400;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               is_last;
		logic [TOTAL_W-1:0] bytes_used;
	} decoded_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [COUNT_W-1:0]    cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	// Decoder state as seen from outside.
	logic [BYTE_W-1:0]    key_mem [KEY_DEPTH];
	logic [COUNT_W-1:0]   count_reg;
	bit                   data_phase;
	int unsigned          keys_seen;
	int unsigned          values_done;
	int unsigned          byte_pos;
	logic [PARTIAL_W-1:0] partial;
	int unsigned          byte_total;

	decoded_t    expected_values[$];
	int unsigned errors;
	int unsigned sent_items;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned hold_cycles;

	stream_vbyte_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #10 clk = ~clk;

	function automatic void restart_decode();
		data_phase = 0;
		keys_seen = 0;
		values_done = 0;
		byte_pos = 0;
		partial = '0;
		byte_total = 0;
	endfunction

	// Advances the decoder state by one accepted byte and queues a value when
	// the byte completes one.
	function automatic void decode_byte(input logic [BYTE_W-1:0] b);
		int unsigned n, key_len, code;
		logic [VALUE_W-1:0] full;
		decoded_t result;
		n = (count_reg > DEFAULT_MAX_COUNT) ? DEFAULT_MAX_COUNT : count_reg;
		if (n == 0)
			return;
		key_len = (n + 3) / 4;
		byte_total++;
		if (!data_phase) begin
			key_mem[keys_seen] = b;
			keys_seen++;
			if (keys_seen >= key_len)
				data_phase = 1;
			return;
		end
		code = (key_mem[values_done / CODES_PER_KEY] >> (CODE_W * (values_done % CODES_PER_KEY)))
			& CODE_MASK;
		if (byte_pos < code) begin
			partial = partial | (PARTIAL_W'(b) << (8 * byte_pos));
			byte_pos++;
			return;
		end
		full = VALUE_W'(partial) | (VALUE_W'(b) << (8 * byte_pos));
		values_done++;
		result.value = full;
		if (values_done >= n) begin
			result.is_last = 1'b1;
			result.bytes_used = TOTAL_W'(byte_total);
			restart_decode();
		end else begin
			result.is_last = 1'b0;
			result.bytes_used = '0;
			byte_pos = 0;
			partial = '0;
		end
		expected_values.push_back(result);
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (count_reg != 0)
			sent_items++;
		decode_byte(b);
		@(negedge clk);
	endtask

	// Sends one block of n values; fixed_key below zero draws random keys, and
	// a byte_limit of zero or more cuts the block short.
	task automatic send_block(input int n, input int fixed_key, input int byte_limit);
		logic [BYTE_W-1:0] keys [KEY_DEPTH];
		int key_len, sent, code;
		key_len = (n + 3) / 4;
		sent = 0;
		for (int k = 0; k < key_len; k++) begin
			keys[k] = (fixed_key < 0) ? BYTE_W'($urandom_range(255)) : BYTE_W'(fixed_key);
			if (byte_limit >= 0 && sent >= byte_limit)
				return;
			send_byte(keys[k]);
			sent++;
		end
		for (int v = 0; v < n; v++) begin
			code = (keys[v / 4] >> (2 * (v % 4))) & CODE_MASK;
			for (int j = 0; j <= code; j++) begin
				if (byte_limit >= 0 && sent >= byte_limit)
					return;
				send_byte(BYTE_W'($urandom_range(255)));
				sent++;
			end
		end
	endtask

	// Bytes that complete no value leave nothing to wait for, so the task also
	// waits on after the last expected value.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_values.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_count(input logic [COUNT_W-1:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		count_reg = v;
		restart_decode();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_zero_count();
		set_count('0);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'hA5);
	endtask

	// Single-value blocks back to back, the smallest and the widest value;
	// unused codes in the key byte must be ignored.
	task automatic test_single_values();
		set_count(COUNT_W'(1));
		send_byte(8'hFC);
		send_byte(8'h00);
		send_byte(8'h03);
		repeat (4) send_byte(8'hFF);
	endtask

	task automatic test_all_lengths();
		set_count(COUNT_W'(4));
		send_byte(8'hE4);
		send_byte(8'h80);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'h03);
		repeat (4) send_byte(8'hFF);
	endtask

	// A write in the middle of a block throws away the partial value.
	task automatic test_restart();
		set_count(COUNT_W'(9));
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		repeat (5) send_byte(BYTE_W'($urandom_range(255)));
		set_count(COUNT_W'(9));
		send_block(9, -1, -1);
	endtask

	// A count beyond the maximum decodes as the maximum, so data bytes start
	// right after the largest possible key area.
	task automatic test_large_blocks();
		set_count('1);
		send_block(DEFAULT_MAX_COUNT, 8'h00, int'(KEY_DEPTH) + 32);
	endtask

	task automatic test_backpressure();
		set_count(COUNT_W'(64));
		hold_cycles = 300;
		send_block(64, 8'h00, -1);
	endtask

	task automatic test_random_blocks();
		int unsigned start, phase, pick, n, blocks;
		start = sent_items;
		while (sent_items - start < RANDOM_ITEMS) begin
			phase = (sent_items - start) * 3 / RANDOM_ITEMS;
			send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 63 : 0;
			recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 7 : 0;
			pick = $urandom_range(99);
			if (pick < 5) begin
				set_count('0);
				repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(255)));
				continue;
			end
			n = (pick < 15) ? $urandom_range(25, 60) : $urandom_range(1, 24);
			set_count(COUNT_W'(n));
			blocks = $urandom_range(1, 3);
			for (int i = 0; i < blocks; i++)
				send_block(n, -1, -1);
			if ($urandom_range(99) < 10)
				send_block(n, -1, $urandom_range(0, (n + 3) / 4 + n));
		end
	endtask

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		decoded_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_values.size() == 0) begin
				$display("%0t: unexpected value: expected none, got %h", $time,
					m_tdata[VALUE_W-1:0]);
				errors++;
			end else begin
				want = expected_values.pop_front();
				if (m_tdata[VALUE_W-1:0] !== want.value) begin
					$display("%0t: value mismatch: expected %h, got %h", $time,
						want.value, m_tdata[VALUE_W-1:0]);
					errors++;
				end
				if (m_tlast !== want.is_last) begin
					$display("%0t: last flag mismatch: expected %b, got %b", $time,
						want.is_last, m_tlast);
					errors++;
				end
				if (m_tdata[VALUE_W+TOTAL_W-1:VALUE_W] !== want.bytes_used) begin
					$display("%0t: byte total mismatch: expected %0d, got %0d", $time,
						want.bytes_used, m_tdata[VALUE_W+TOTAL_W-1:VALUE_W]);
					errors++;
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		errors = 0;
		sent_items = 0;
		send_idle_pct = 7;
		recv_idle_pct = 63;
		hold_cycles = 0;
		count_reg = '0;
		restart_decode();
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_zero_count();
		test_single_values();
		test_all_lengths();
		test_restart();
		test_backpressure();
		test_large_blocks();
		test_random_blocks();

		wait_idle();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
